// ===== hdl/wpr_pkg.sv =====
// shared types and constants of the weighted proposer rotation block
package wpr_pkg;

	localparam int ADDR_W          = 64;
	localparam int POWER_W         = 32;
	localparam int ACCUM_W         = 64;
	localparam int REPS_W          = 8;
	localparam int PROD_W          = POWER_W + REPS_W;
	localparam int TOTAL_OUT_W     = 36;
	localparam int MAX_ENTRIES_DEF = 16;

	localparam logic [TOTAL_OUT_W-1:0] TOTAL_OUT_MAX = '1;

	// command codes
	localparam logic [1:0] CMD_ADD     = 2'd0;
	localparam logic [1:0] CMD_REMOVE  = 2'd1;
	localparam logic [1:0] CMD_UPDATE  = 2'd2;
	localparam logic [1:0] CMD_ADVANCE = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_MISS  = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [1:0]                command;
		logic [ADDR_W-1:0]         member_address;
		logic [POWER_W-1:0]        member_power;
		logic signed [ACCUM_W-1:0] member_accum;
		logic [REPS_W-1:0]         repeat_count;
	} req_t;

	typedef struct packed {
		logic [1:0]             status;
		logic                   proposer_valid;
		logic [ADDR_W-1:0]      proposer_address;
		logic [TOTAL_OUT_W-1:0] total_power;
	} res_t;

	// one table row as stored in the ram
	typedef struct packed {
		logic [ADDR_W-1:0]         address;
		logic [POWER_W-1:0]        power;
		logic signed [ACCUM_W-1:0] accum;
	} entry_t;

	// request to the shared saturating unit
	typedef struct packed {
		logic signed [ACCUM_W-1:0] a;
		logic [ACCUM_W-1:0]        b;
		logic                      sub;
	} alu_op_t;

endpackage

// ===== hdl/wpr_stream_if.sv =====
// valid/ready stream interface carrying one payload item per handshake
interface wpr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hdl/wpr_ram.sv =====
// generic single-write, single-read ram with registered read data
module wpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/wpr_alu.sv =====
// shared saturating accumulator unit: a + b or a - b clamped to signed 64-bit range
module wpr_alu
	import wpr_pkg::*;
(
	input  alu_op_t                   op,
	output logic signed [ACCUM_W-1:0] y
);

	logic [ACCUM_W:0] ext_a;
	logic [ACCUM_W:0] ext_b;
	logic [ACCUM_W:0] res;

	always_comb begin
		ext_a = {op.a[ACCUM_W-1], op.a};
		ext_b = {1'b0, op.b};
		res   = op.sub ? (ext_a - ext_b) : (ext_a + ext_b);
		// b is never negative, so an add can only overflow upward and a subtract downward
		if (res[ACCUM_W] != res[ACCUM_W-1]) begin
			y = op.sub ? {1'b1, {(ACCUM_W-1){1'b0}}} : {1'b0, {(ACCUM_W-1){1'b1}}};
		end else begin
			y = res[ACCUM_W-1:0];
		end
	end

endmodule

// ===== hdl/weighted_proposer_rotation.sv =====
// Weighted proposer rotation: a table of up to MAX_ENTRIES members (address, voting power,
// signed accumulator) held in one ram, with a sequencer that walks the table through the
// ram's single read port and one shared saturating add/subtract unit. One item is taken at
// a time. Add, remove and update each make one lookup pass over the table. An advance makes
// one pass that adds power times repeat_count to every accumulator, then one search pass
// and one write-back per round. An advance on an empty table or with a repeat count of zero
// goes straight to the finish state without a pass. A previous result that is not yet taken
// holds the block in its finish state until it is. The total power is kept in a running
// register, so it costs no pass.
// The result is held in an output register, so the next item is accepted while it waits.
module weighted_proposer_rotation
	import wpr_pkg::*;
#(
	parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
	input logic          clk,
	input logic          arst_n,
	wpr_stream_if.sink   req,
	wpr_stream_if.source rsp
);

	localparam int IDX_W   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int TOTAL_W = POWER_W + $clog2(MAX_ENTRIES + 1);
	localparam int ENT_W   = $bits(entry_t);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_APPLY,
		S_SUB,
		S_FINISH
	} state_t;

	typedef enum logic [1:0] {
		M_FIND,
		M_ACC,
		M_PICK
	} mode_t;

	state_t state_q;
	mode_t  mode_q;
	req_t   cmd_q;

	logic [MAX_ENTRIES-1:0] used_q;
	logic [TOTAL_W-1:0]     total_q;
	logic                   prop_set_q;
	logic [ADDR_W-1:0]      prop_addr_q;
	logic [1:0]             status_q;
	logic [REPS_W-1:0]      rounds_q;

	// scan pipeline: read issue, ram data, scaled product
	logic               issue_q;
	logic [IDX_W-1:0]   ptr_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               vld_s2;
	logic [IDX_W-1:0]   idx_s2;
	entry_t             data_s2;
	logic [PROD_W-1:0]  prod_s2;

	// lookup results
	logic               found_q;
	logic [IDX_W-1:0]   found_idx_q;
	logic [POWER_W-1:0] found_pow_q;
	logic               free_q;
	logic [IDX_W-1:0]   free_idx_q;

	// running best of a pick pass
	logic                      best_vld_q;
	logic signed [ACCUM_W-1:0] best_acc_q;
	logic [ADDR_W-1:0]         best_addr_q;
	logic [POWER_W-1:0]        best_pow_q;
	logic [IDX_W-1:0]          best_idx_q;

	logic               rsp_vld_q;
	res_t               rsp_data_q;

	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_ent;
	logic [ENT_W-1:0]   rd_data;
	entry_t             rd_ent;
	alu_op_t            alu_op;
	logic signed [ACCUM_W-1:0] alu_y;
	logic               scan_done;
	logic               add_ok;
	logic               upd_ok;
	logic               better;

	assign rd_ent    = entry_t'(rd_data);
	assign scan_done = !issue_q && !vld_s1 && !vld_s2;
	assign add_ok    = (cmd_q.command == CMD_ADD) && !found_q && free_q;
	assign upd_ok    = (cmd_q.command == CMD_UPDATE) && found_q;
	assign better    = !best_vld_q || ($signed(rd_ent.accum) > best_acc_q) ||
		(($signed(rd_ent.accum) == best_acc_q) && (rd_ent.address < best_addr_q));

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_vld_q;
	assign rsp.payload = rsp_data_q;

	wpr_ram #(
		.WIDTH(ENT_W),
		.DEPTH(MAX_ENTRIES)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_ent),
		.rd_en  (issue_q),
		.rd_addr(ptr_q),
		.rd_data(rd_data)
	);

	wpr_alu u_alu (
		.op(alu_op),
		.y (alu_y)
	);

	// write port and shared unit selection
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = idx_s2;
		wr_ent  = data_s2;
		alu_op  = '{a: data_s2.accum, b: ACCUM_W'(prod_s2), sub: 1'b0};
		if (state_q == S_SCAN && vld_s2) begin
			wr_en        = 1'b1;
			wr_ent.accum = alu_y;
		end else if (state_q == S_SUB) begin
			alu_op  = '{a: best_acc_q, b: ACCUM_W'(total_q), sub: 1'b1};
			wr_en   = 1'b1;
			wr_addr = best_idx_q;
			wr_ent  = '{address: best_addr_q, power: best_pow_q, accum: alu_y};
		end else if (state_q == S_APPLY && (add_ok || upd_ok)) begin
			wr_en   = 1'b1;
			wr_addr = add_ok ? free_idx_q : found_idx_q;
			wr_ent  = '{address: cmd_q.member_address, power: cmd_q.member_power,
				accum: cmd_q.member_accum};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			mode_q     <= M_FIND;
			used_q     <= '0;
			total_q    <= '0;
			prop_set_q <= 1'b0;
			status_q   <= ST_OK;
			rounds_q   <= '0;
			issue_q    <= 1'b0;
			ptr_q      <= '0;
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			best_vld_q <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end

			// read issue and data pipeline, active in any scan
			if (issue_q) begin
				if (ptr_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					ptr_q <= ptr_q + IDX_W'(1);
				end
			end
			vld_s1 <= issue_q;
			idx_s1 <= ptr_q;
			vld_s2 <= vld_s1 && (mode_q == M_ACC) && used_q[idx_s1];
			idx_s2 <= idx_s1;
			data_s2 <= rd_ent;
			prod_s2 <= PROD_W'(rd_ent.power) * PROD_W'(cmd_q.repeat_count);

			if (vld_s1) begin
				if (mode_q == M_FIND) begin
					if (used_q[idx_s1] && rd_ent.address == cmd_q.member_address) begin
						found_q     <= 1'b1;
						found_idx_q <= idx_s1;
						found_pow_q <= rd_ent.power;
					end
					if (!used_q[idx_s1] && !free_q) begin
						free_q     <= 1'b1;
						free_idx_q <= idx_s1;
					end
				end else if (mode_q == M_PICK && used_q[idx_s1] && better) begin
					best_vld_q  <= 1'b1;
					best_acc_q  <= rd_ent.accum;
					best_addr_q <= rd_ent.address;
					best_pow_q  <= rd_ent.power;
					best_idx_q  <= idx_s1;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q    <= req.payload;
						status_q <= ST_OK;
						rounds_q <= req.payload.repeat_count;
						found_q  <= 1'b0;
						free_q   <= 1'b0;
						ptr_q    <= '0;
						if (req.payload.command == CMD_ADVANCE) begin
							if (used_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_FINISH;
							end else if (req.payload.repeat_count == '0) begin
								state_q <= S_FINISH;
							end else begin
								mode_q  <= M_ACC;
								issue_q <= 1'b1;
								state_q <= S_SCAN;
							end
						end else begin
							mode_q  <= M_FIND;
							issue_q <= 1'b1;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_done) begin
						unique case (mode_q)
							M_FIND: state_q <= S_APPLY;
							M_ACC: begin
								// accumulation pass done, start the first pick pass
								mode_q     <= M_PICK;
								ptr_q      <= '0;
								issue_q    <= 1'b1;
								best_vld_q <= 1'b0;
							end
							M_PICK: state_q <= S_SUB;
							default: state_q <= S_SUB;
						endcase
					end
				end
				S_APPLY: begin
					unique case (cmd_q.command)
						CMD_ADD: begin
							if (found_q) begin
								status_q <= ST_MISS;
							end else if (!free_q) begin
								status_q <= ST_FULL;
							end else begin
								used_q[free_idx_q] <= 1'b1;
								total_q    <= total_q + TOTAL_W'(cmd_q.member_power);
								prop_set_q <= 1'b0;
							end
						end
						CMD_REMOVE: begin
							if (!found_q) begin
								status_q <= ST_MISS;
							end else begin
								used_q[found_idx_q] <= 1'b0;
								total_q    <= total_q - TOTAL_W'(found_pow_q);
								prop_set_q <= 1'b0;
							end
						end
						CMD_UPDATE: begin
							if (!found_q) begin
								status_q <= ST_MISS;
							end else begin
								total_q <= total_q - TOTAL_W'(found_pow_q)
									+ TOTAL_W'(cmd_q.member_power);
								prop_set_q <= 1'b0;
							end
						end
						default: status_q <= ST_MISS;
					endcase
					state_q <= S_FINISH;
				end
				S_SUB: begin
					prop_set_q  <= 1'b1;
					prop_addr_q <= best_addr_q;
					if (rounds_q == REPS_W'(1)) begin
						state_q <= S_FINISH;
					end else begin
						rounds_q   <= rounds_q - REPS_W'(1);
						ptr_q      <= '0;
						issue_q    <= 1'b1;
						best_vld_q <= 1'b0;
						state_q    <= S_SCAN;
					end
				end
				S_FINISH: begin
					if (!rsp_vld_q || rsp.ready) begin
						rsp_vld_q                   <= 1'b1;
						rsp_data_q.status           <= status_q;
						rsp_data_q.proposer_valid   <= prop_set_q;
						rsp_data_q.proposer_address <= prop_set_q ? prop_addr_q : '0;
						rsp_data_q.total_power      <=
							(64'(total_q) > 64'(TOTAL_OUT_MAX)) ?
							TOTAL_OUT_MAX : TOTAL_OUT_W'(total_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
